>>> rtl/core/assert_macros.svh
// assertion macros used by the checker file ffea_chk.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/ffea_pkg.sv
`default_nettype none

package ffea_pkg;

    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] KIND_INVALID = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_BAD_KIND   = 3'd2;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
    localparam logic [2:0] ST_NO_SPACE   = 3'd4;
    localparam logic [2:0] ST_BAD_INDEX  = 3'd5;

    localparam logic CFG_SPC = 1'b0;
    localparam logic CFG_CYL = 1'b1;

    // linear address width: cylinder * spc + sector + length
    localparam int LIN_W = 34;
    localparam int DIV_STEPS = LIN_W;
    localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS - 1);

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  requested_kind;
        logic [31:0] requested_length;
        logic [2:0]  entry_index;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] base_cylinder;
        logic [15:0] base_sector;
        logic [31:0] extent_length;
        logic [1:0]  extent_kind;
        logic [3:0]  entries_in_use;
    } rsp_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_START,
        DP_TAB_RD,
        DP_LOAD_KEY,
        DP_SRT_RD,
        DP_SEL_I,
        DP_SEL_J,
        DP_SWAP_A,
        DP_SWAP_B,
        DP_ADVANCE,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_PLACE,
        DP_TAB_MOVE,
        DP_RESULT
    } dp_op_t;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_TABLE,
        SRC_NEW
    } res_src_t;

    typedef struct packed {
        dp_op_t     op;
        res_src_t   src;
        logic [2:0] status;
    } dp_cmd_t;

    typedef struct packed {
        logic fit_gap;
        logic fit_end;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/ffea_dp.sv
`default_nettype none

module ffea_dp #(
    parameter int MAX_VOLUMES = 8,
    parameter int IW = 3,
    parameter int CW = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ffea_pkg::req_t    req,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire ffea_pkg::dp_cmd_t cmd,
    input  wire logic [IW-1:0]     addr,
    input  wire logic [CW-1:0]     count,
    output ffea_pkg::dp_stat_t     stat,
    output ffea_pkg::rsp_t         rsp
);

    typedef struct packed {
        logic [15:0] cyl;
        logic [15:0] sec;
        logic [31:0] len;
        logic [1:0]  kind;
    } entry_t;

    typedef struct packed {
        logic [ffea_pkg::LIN_W-2:0] start;
        logic [ffea_pkg::LIN_W-1:0] stop;
    } key_t;

    entry_t tab_mem [MAX_VOLUMES];
    key_t   srt_mem [MAX_VOLUMES];

    logic [15:0] spc_reg;
    logic [15:0] cyl_reg;
    logic [15:0] spc_eff;

    entry_t tq_reg;
    key_t   sq_reg;
    key_t   cur_reg;
    key_t   best_reg;
    logic [IW-1:0] best_idx_reg;

    logic [ffea_pkg::LIN_W-1:0] pos_reg;
    logic [31:0]                total_reg;
    logic [31:0]                want_reg;
    logic [1:0]                 kind_reg;
    logic [ffea_pkg::LIN_W-1:0] div_reg;
    logic [15:0]                rem_reg;
    ffea_pkg::rsp_t             rsp_reg;

    logic [31:0] prod;
    key_t        new_key;
    logic signed [ffea_pkg::LIN_W+1:0] gap;
    logic signed [ffea_pkg::LIN_W+1:0] gap_end;
    logic signed [ffea_pkg::LIN_W+1:0] want_s;
    logic [16:0] rem_sh;
    logic        rem_ge;

    logic           srt_we;
    logic [IW-1:0]  srt_wa;
    key_t           srt_wd;
    logic           tab_we;
    entry_t         tab_wd;

    assign spc_eff = (spc_reg == 16'd0) ? 16'd1 : spc_reg;

    assign prod = tq_reg.cyl * spc_eff;
    assign new_key.start = (ffea_pkg::LIN_W-1)'(prod) + (ffea_pkg::LIN_W-1)'(tq_reg.sec);
    assign new_key.stop  = ffea_pkg::LIN_W'(new_key.start) + ffea_pkg::LIN_W'(tq_reg.len);

    assign want_s  = $signed((ffea_pkg::LIN_W+2)'(want_reg));
    assign gap     = $signed((ffea_pkg::LIN_W+2)'(sq_reg.start))
                   - $signed((ffea_pkg::LIN_W+2)'(pos_reg));
    assign gap_end = $signed((ffea_pkg::LIN_W+2)'(total_reg))
                   - $signed((ffea_pkg::LIN_W+2)'(pos_reg));
    assign stat.fit_gap = (gap >= want_s);
    assign stat.fit_end = (gap_end >= want_s);

    assign rem_sh = {rem_reg, div_reg[ffea_pkg::LIN_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, spc_eff});

    always_comb
    begin
        srt_we = 1'b0;
        srt_wa = addr;
        srt_wd = new_key;
        tab_we = 1'b0;
        tab_wd = tq_reg;
        case (cmd.op)
            ffea_pkg::DP_LOAD_KEY:
            begin
                srt_we = 1'b1;
            end
            ffea_pkg::DP_SWAP_A:
            begin
                srt_we = 1'b1;
                srt_wd = best_reg;
            end
            ffea_pkg::DP_SWAP_B:
            begin
                srt_we = 1'b1;
                srt_wa = best_idx_reg;
                srt_wd = cur_reg;
            end
            ffea_pkg::DP_TAB_MOVE:
            begin
                tab_we = 1'b1;
            end
            ffea_pkg::DP_PLACE:
            begin
                tab_we = 1'b1;
                tab_wd = '{cyl: div_reg[15:0], sec: rem_reg, len: want_reg, kind: kind_reg};
            end
            default:
            begin
                srt_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (srt_we)
        begin
            srt_mem[srt_wa] <= srt_wd;
        end
        if (tab_we)
        begin
            tab_mem[addr] <= tab_wd;
        end
        if (cmd.op == ffea_pkg::DP_TAB_RD)
        begin
            tq_reg <= tab_mem[addr];
        end
        if (cmd.op == ffea_pkg::DP_SRT_RD)
        begin
            sq_reg <= srt_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spc_reg <= 16'd16;
            cyl_reg <= 16'd16;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ffea_pkg::CFG_SPC)
            begin
                spc_reg <= cfg_data;
            end
            else
            begin
                cyl_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ffea_pkg::DP_START:
            begin
                want_reg  <= req.requested_length;
                kind_reg  <= req.requested_kind;
                total_reg <= cyl_reg * spc_eff;
                pos_reg   <= ffea_pkg::LIN_W'(1);
            end
            ffea_pkg::DP_SEL_I:
            begin
                cur_reg      <= sq_reg;
                best_reg     <= sq_reg;
                best_idx_reg <= addr;
            end
            ffea_pkg::DP_SEL_J:
            begin
                if (sq_reg.start < best_reg.start)
                begin
                    best_reg     <= sq_reg;
                    best_idx_reg <= addr;
                end
            end
            ffea_pkg::DP_ADVANCE:
            begin
                pos_reg <= sq_reg.stop;
            end
            ffea_pkg::DP_DIV_INIT:
            begin
                div_reg <= pos_reg;
                rem_reg <= 16'd0;
            end
            ffea_pkg::DP_DIV_STEP:
            begin
                rem_reg <= rem_ge ? 16'(rem_sh - {1'b0, spc_eff}) : rem_sh[15:0];
                div_reg <= {div_reg[ffea_pkg::LIN_W-2:0], rem_ge};
            end
            ffea_pkg::DP_RESULT:
            begin
                rsp_reg.status         <= cmd.status;
                rsp_reg.entries_in_use <= 4'(count);
                case (cmd.src)
                    ffea_pkg::SRC_TABLE:
                    begin
                        rsp_reg.base_cylinder <= tq_reg.cyl;
                        rsp_reg.base_sector   <= tq_reg.sec;
                        rsp_reg.extent_length <= tq_reg.len;
                        rsp_reg.extent_kind   <= tq_reg.kind;
                    end
                    ffea_pkg::SRC_NEW:
                    begin
                        rsp_reg.base_cylinder <= div_reg[15:0];
                        rsp_reg.base_sector   <= rem_reg;
                        rsp_reg.extent_length <= want_reg;
                        rsp_reg.extent_kind   <= kind_reg;
                    end
                    default:
                    begin
                        rsp_reg.base_cylinder <= 16'd0;
                        rsp_reg.base_sector   <= 16'd0;
                        rsp_reg.extent_length <= 32'd0;
                        rsp_reg.extent_kind   <= 2'd0;
                    end
                endcase
            end
            default:
            begin
                pos_reg <= pos_reg;
            end
        endcase
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

>>> rtl/core/ffea_ctrl.sv
`default_nettype none

module ffea_ctrl #(
    parameter int MAX_VOLUMES = 8,
    parameter int IW = 3,
    parameter int CW = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire ffea_pkg::req_t     req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output ffea_pkg::dp_cmd_t       cmd,
    output logic [IW-1:0]           addr,
    output logic [CW-1:0]           count,
    input  wire ffea_pkg::dp_stat_t stat
);

    localparam int XW = CW + 3;
    localparam logic [CW-1:0] MAX_N = CW'(MAX_VOLUMES);

    typedef enum logic [4:0] {
        IDLE,
        LD_RD,
        LD_WR,
        SR_RI,
        SR_CI,
        SR_RJ,
        SR_CJ,
        SR_W1,
        SR_W2,
        SC_RD,
        SC_CHK,
        SC_END,
        DV_INIT,
        DV_STEP,
        PLACE,
        DL_CHK,
        DL_RD,
        DL_WR,
        RD_RD,
        FIN
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [CW-1:0]        j_reg, j_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [5:0]           dcnt_reg, dcnt_next;
    logic [2:0]           st_reg, st_next;
    ffea_pkg::res_src_t   src_reg, src_next;
    logic                 valid_reg, valid_next;

    logic          accept;
    logic          bad_idx;
    logic [CW-1:0] idx_c;
    logic          slot_free;

    assign accept    = req_valid && req_ready;
    assign bad_idx   = XW'(req.entry_index) >= XW'(n_reg);
    assign idx_c     = CW'(XW'(req.entry_index));
    assign slot_free = !valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        dcnt_next  = dcnt_reg;
        st_next    = st_reg;
        src_next   = src_reg;
        valid_next = valid_reg && !rsp_ready;
        cmd        = '{op: ffea_pkg::DP_NONE, src: src_reg, status: st_reg};
        addr       = i_reg[IW-1:0];
        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    cmd.op   = ffea_pkg::DP_START;
                    st_next  = ffea_pkg::ST_OK;
                    src_next = ffea_pkg::SRC_NONE;
                    i_next   = '0;
                    case (req.command)
                        ffea_pkg::CMD_CREATE:
                        begin
                            if (n_reg >= MAX_N)
                            begin
                                st_next    = ffea_pkg::ST_FULL;
                                state_next = FIN;
                            end
                            else if (req.requested_kind == ffea_pkg::KIND_INVALID)
                            begin
                                st_next    = ffea_pkg::ST_BAD_KIND;
                                state_next = FIN;
                            end
                            else if (req.requested_length == 32'd0)
                            begin
                                st_next    = ffea_pkg::ST_BAD_LENGTH;
                                state_next = FIN;
                            end
                            else if (n_reg == '0)
                            begin
                                state_next = SC_END;
                            end
                            else
                            begin
                                state_next = LD_RD;
                            end
                        end
                        ffea_pkg::CMD_DELETE:
                        begin
                            if (bad_idx)
                            begin
                                st_next    = ffea_pkg::ST_BAD_INDEX;
                                state_next = FIN;
                            end
                            else
                            begin
                                i_next     = idx_c;
                                state_next = DL_CHK;
                            end
                        end
                        ffea_pkg::CMD_READ:
                        begin
                            if (bad_idx)
                            begin
                                st_next    = ffea_pkg::ST_BAD_INDEX;
                                state_next = FIN;
                            end
                            else
                            begin
                                i_next     = idx_c;
                                state_next = RD_RD;
                            end
                        end
                        default:
                        begin
                            state_next = FIN;
                        end
                    endcase
                end
            end
            LD_RD:
            begin
                cmd.op     = ffea_pkg::DP_TAB_RD;
                state_next = LD_WR;
            end
            LD_WR:
            begin
                cmd.op = ffea_pkg::DP_LOAD_KEY;
                if (i_reg == n_reg - 1'b1)
                begin
                    i_next     = '0;
                    state_next = (n_reg > CW'(1)) ? SR_RI : SC_RD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = LD_RD;
                end
            end
            SR_RI:
            begin
                cmd.op     = ffea_pkg::DP_SRT_RD;
                state_next = SR_CI;
            end
            SR_CI:
            begin
                cmd.op     = ffea_pkg::DP_SEL_I;
                j_next     = i_reg + 1'b1;
                state_next = SR_RJ;
            end
            SR_RJ:
            begin
                cmd.op     = ffea_pkg::DP_SRT_RD;
                addr       = j_reg[IW-1:0];
                state_next = SR_CJ;
            end
            SR_CJ:
            begin
                cmd.op = ffea_pkg::DP_SEL_J;
                addr   = j_reg[IW-1:0];
                if (j_reg == n_reg - 1'b1)
                begin
                    state_next = SR_W1;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = SR_RJ;
                end
            end
            SR_W1:
            begin
                cmd.op     = ffea_pkg::DP_SWAP_A;
                state_next = SR_W2;
            end
            SR_W2:
            begin
                cmd.op = ffea_pkg::DP_SWAP_B;
                if (i_reg == n_reg - CW'(2))
                begin
                    i_next     = '0;
                    state_next = SC_RD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = SR_RI;
                end
            end
            SC_RD:
            begin
                cmd.op     = ffea_pkg::DP_SRT_RD;
                state_next = SC_CHK;
            end
            SC_CHK:
            begin
                if (stat.fit_gap)
                begin
                    state_next = DV_INIT;
                end
                else
                begin
                    cmd.op = ffea_pkg::DP_ADVANCE;
                    if (i_reg == n_reg - 1'b1)
                    begin
                        state_next = SC_END;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = SC_RD;
                    end
                end
            end
            SC_END:
            begin
                if (stat.fit_end)
                begin
                    state_next = DV_INIT;
                end
                else
                begin
                    st_next    = ffea_pkg::ST_NO_SPACE;
                    state_next = FIN;
                end
            end
            DV_INIT:
            begin
                cmd.op     = ffea_pkg::DP_DIV_INIT;
                dcnt_next  = '0;
                state_next = DV_STEP;
            end
            DV_STEP:
            begin
                cmd.op    = ffea_pkg::DP_DIV_STEP;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == ffea_pkg::DIV_LAST)
                begin
                    state_next = PLACE;
                end
            end
            PLACE:
            begin
                cmd.op     = ffea_pkg::DP_PLACE;
                addr       = n_reg[IW-1:0];
                n_next     = n_reg + 1'b1;
                src_next   = ffea_pkg::SRC_NEW;
                state_next = FIN;
            end
            DL_CHK:
            begin
                if (XW'(i_reg) + XW'(1) < XW'(n_reg))
                begin
                    state_next = DL_RD;
                end
                else
                begin
                    n_next     = n_reg - 1'b1;
                    state_next = FIN;
                end
            end
            DL_RD:
            begin
                cmd.op     = ffea_pkg::DP_TAB_RD;
                addr       = IW'(i_reg + 1'b1);
                state_next = DL_WR;
            end
            DL_WR:
            begin
                cmd.op     = ffea_pkg::DP_TAB_MOVE;
                i_next     = i_reg + 1'b1;
                state_next = DL_CHK;
            end
            RD_RD:
            begin
                cmd.op     = ffea_pkg::DP_TAB_RD;
                src_next   = ffea_pkg::SRC_TABLE;
                state_next = FIN;
            end
            FIN:
            begin
                if (slot_free)
                begin
                    cmd.op     = ffea_pkg::DP_RESULT;
                    valid_next = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            n_reg     <= '0;
            dcnt_reg  <= '0;
            st_reg    <= ffea_pkg::ST_OK;
            src_reg   <= ffea_pkg::SRC_NONE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
            dcnt_reg  <= dcnt_next;
            st_reg    <= st_next;
            src_reg   <= src_next;
            valid_reg <= valid_next;
        end
    end

    assign req_ready = (state_reg == IDLE);
    assign rsp_valid = valid_reg;
    assign count     = n_reg;

endmodule

`default_nettype wire

>>> rtl/core/first_fit_extent_allocator.sv
`default_nettype none

// First-fit extent allocator over a table of up to MAX_VOLUMES extents. One command word
// is taken at a time. The response word sits in an output register, so a new command is
// taken while a response waits. A response that is not taken holds the next command in
// its final step. After a setup step, create on a non-empty table loads the keys of all
// entries, runs a selection sort over one single-port key memory and scans the gaps in
// start order; on a fit a radix-2 divider splits the start into cylinder and sector, and
// placement and result steps follow. Create on an empty table goes straight to the end
// check. Delete shifts each later entry down by one slot, read fetches its entry, and
// rejected commands go straight to the result step. The user must write the geometry
// registers through the cfg port only while no command is in flight; the block itself
// does not enforce this. A sectors per cylinder of zero acts as one.
module first_fit_extent_allocator #(
    parameter int MAX_VOLUMES = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire ffea_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output ffea_pkg::rsp_t       rsp,
    input  wire logic            cfg_we,
    input  wire logic            cfg_index,
    input  wire logic [15:0]     cfg_data
);

    localparam int IW = (MAX_VOLUMES > 1) ? $clog2(MAX_VOLUMES) : 1;
    localparam int CW = $clog2(MAX_VOLUMES + 1);

    ffea_pkg::dp_cmd_t  cmd;
    ffea_pkg::dp_stat_t stat;
    logic [IW-1:0]      addr;
    logic [CW-1:0]      count;

    ffea_ctrl #(
        .MAX_VOLUMES(MAX_VOLUMES),
        .IW(IW),
        .CW(CW)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .cmd(cmd),
        .addr(addr),
        .count(count),
        .stat(stat)
    );

    ffea_dp #(
        .MAX_VOLUMES(MAX_VOLUMES),
        .IW(IW),
        .CW(CW)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cmd(cmd),
        .addr(addr),
        .count(count),
        .stat(stat),
        .rsp(rsp)
    );

endmodule

`default_nettype wire

>>> rtl/core/ffea_chk.sv
`default_nettype none

`include "assert_macros.svh"

module ffea_chk #(
    parameter int MAX_VOLUMES = 8
) (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_ready,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire ffea_pkg::rsp_t rsp
);

    logic rsp_err;
    logic fields_zero;

    assign rsp_err     = rsp_valid && (rsp.status != ffea_pkg::ST_OK);
    assign fields_zero = (rsp.base_cylinder == 16'd0) && (rsp.base_sector == 16'd0)
                      && (rsp.extent_length == 32'd0) && (rsp.extent_kind == 2'd0);

    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    `ASSERT_SAME(a_count_bound, clk, rst_n, rsp_valid, 32'(rsp.entries_in_use) <= MAX_VOLUMES)

    `ASSERT_SAME(a_err_zero, clk, rst_n, rsp_err, fields_zero)

    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready)

endmodule

bind first_fit_extent_allocator ffea_chk #(.MAX_VOLUMES(MAX_VOLUMES)) u_ffea_chk (
    .clk(clk),
    .rst_n(rst_n),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
);

`default_nettype wire

>>> verif/tb_first_fit_extent_allocator.sv
`timescale 1ns / 1ps

module tb_first_fit_extent_allocator;

    localparam int TABLE_DEPTH = 8;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    ffea_pkg::req_t    req;
    logic              rsp_valid;
    logic              rsp_ready;
    ffea_pkg::rsp_t    rsp;
    logic              cfg_we;
    logic              cfg_index;
    logic [15:0]       cfg_data;

    first_fit_extent_allocator #(.MAX_VOLUMES(TABLE_DEPTH)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the partition table and geometry
    logic [15:0] geo_spc;
    logic [15:0] geo_cyl;
    logic [15:0] cyl_tab [TABLE_DEPTH];
    logic [15:0] sec_tab [TABLE_DEPTH];
    logic [31:0] len_tab [TABLE_DEPTH];
    logic [1:0]  kind_tab [TABLE_DEPTH];
    int          vol_count;

    ffea_pkg::rsp_t pending_results [$];
    int             mismatch_count;
    int             result_count;
    int             creates_placed;
    int             hold_cycles;
    bit             quiet_run;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("DONE: errors detected");
        $finish;
    end

    function automatic longint extent_start(int e);
        longint spc;
        spc = (geo_spc == 16'd0) ? 64'd1 : longint'(geo_spc);
        return longint'(cyl_tab[e]) * spc + longint'(sec_tab[e]);
    endfunction

    function automatic ffea_pkg::rsp_t apply_command(ffea_pkg::req_t w);
        ffea_pkg::rsp_t r;
        int     ord [TABLE_DEPTH];
        int     best;
        int     tmp;
        longint spc;
        longint total;
        longint pos;
        longint gap;
        bit     placed;
        r = '0;
        r.status = ffea_pkg::ST_OK;
        spc = (geo_spc == 16'd0) ? 64'd1 : longint'(geo_spc);
        case (w.command)
            ffea_pkg::CMD_CREATE:
            begin
                if (vol_count >= TABLE_DEPTH)
                    r.status = ffea_pkg::ST_FULL;
                else if (w.requested_kind == ffea_pkg::KIND_INVALID)
                    r.status = ffea_pkg::ST_BAD_KIND;
                else if (w.requested_length == 32'd0)
                    r.status = ffea_pkg::ST_BAD_LENGTH;
                else
                begin
                    for (int i = 0; i < vol_count; i++)
                        ord[i] = i;
                    for (int i = 0; i + 1 < vol_count; i++)
                    begin
                        best = i;
                        for (int j = i + 1; j < vol_count; j++)
                            if (extent_start(ord[j]) < extent_start(ord[best]))
                                best = j;
                        tmp = ord[best];
                        ord[best] = ord[i];
                        ord[i] = tmp;
                    end
                    total = longint'(geo_cyl) * spc;
                    pos = 1;
                    placed = 0;
                    for (int i = 0; i <= vol_count && !placed; i++)
                    begin
                        gap = (i < vol_count) ? extent_start(ord[i]) - pos : total - pos;
                        if (gap >= longint'(w.requested_length))
                        begin
                            cyl_tab[vol_count] = 16'(pos / spc);
                            sec_tab[vol_count] = 16'(pos % spc);
                            len_tab[vol_count] = w.requested_length;
                            kind_tab[vol_count] = w.requested_kind;
                            r.base_cylinder = cyl_tab[vol_count];
                            r.base_sector = sec_tab[vol_count];
                            r.extent_length = w.requested_length;
                            r.extent_kind = w.requested_kind;
                            vol_count++;
                            placed = 1;
                            creates_placed++;
                        end
                        else if (i < vol_count)
                            pos = extent_start(ord[i]) + longint'(len_tab[ord[i]]);
                    end
                    if (!placed)
                        r.status = ffea_pkg::ST_NO_SPACE;
                end
            end
            ffea_pkg::CMD_DELETE:
            begin
                if (int'(w.entry_index) >= vol_count)
                    r.status = ffea_pkg::ST_BAD_INDEX;
                else
                begin
                    for (int i = int'(w.entry_index); i + 1 < vol_count; i++)
                    begin
                        cyl_tab[i] = cyl_tab[i + 1];
                        sec_tab[i] = sec_tab[i + 1];
                        len_tab[i] = len_tab[i + 1];
                        kind_tab[i] = kind_tab[i + 1];
                    end
                    vol_count--;
                end
            end
            ffea_pkg::CMD_READ:
            begin
                if (int'(w.entry_index) >= vol_count)
                    r.status = ffea_pkg::ST_BAD_INDEX;
                else
                begin
                    r.base_cylinder = cyl_tab[w.entry_index];
                    r.base_sector = sec_tab[w.entry_index];
                    r.extent_length = len_tab[w.entry_index];
                    r.extent_kind = kind_tab[w.entry_index];
                end
            end
            default:
            begin
            end
        endcase
        r.entries_in_use = 4'(vol_count);
        return r;
    endfunction

    task automatic send_word(ffea_pkg::req_t w);
        if (!quiet_run && $urandom_range(99) < 27)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        do
            @(posedge clk);
        while (!req_ready);
        pending_results.push_back(apply_command(w));
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic set_geometry(logic [15:0] spc, logic [15:0] cyl);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= ffea_pkg::CFG_SPC;
        cfg_data <= spc;
        @(posedge clk);
        cfg_index <= ffea_pkg::CFG_CYL;
        cfg_data <= cyl;
        @(posedge clk);
        cfg_we <= 1'b0;
        geo_spc = spc;
        geo_cyl = cyl;
        @(posedge clk);
    endtask

    function automatic ffea_pkg::req_t make_word(logic [1:0] c, logic [1:0] k,
                                                 logic [31:0] l, logic [2:0] x);
        ffea_pkg::req_t w;
        w.command = c;
        w.requested_kind = k;
        w.requested_length = l;
        w.entry_index = x;
        return w;
    endfunction

    function automatic ffea_pkg::req_t random_word();
        logic [31:0] l;
        longint      span;
        int unsigned hi;
        int          pick;
        pick = $urandom_range(99);
        span = longint'(geo_cyl) * ((geo_spc == 16'd0) ? 64'd1 : longint'(geo_spc));
        hi = (span > 4096) ? 32'(span / 6) + 32'd1 : 32'(span);
        if (pick < 55)
        begin
            case ($urandom_range(9))
                0: l = $urandom();
                1: l = 32'd0;
                default: l = 32'($urandom_range(1, hi));
            endcase
            return make_word(ffea_pkg::CMD_CREATE,
                             ($urandom_range(19) == 0) ? ffea_pkg::KIND_INVALID
                             : 2'($urandom_range(2)), l, 3'($urandom()));
        end
        else if (pick < 78)
            return make_word(ffea_pkg::CMD_DELETE, 2'($urandom()), $urandom(),
                             3'($urandom_range(0, (vol_count > 0) ? vol_count : 7)));
        else if (pick < 97)
            return make_word(ffea_pkg::CMD_READ, 2'($urandom()), $urandom(),
                             3'($urandom_range(0, (vol_count > 0) ? vol_count : 7)));
        return make_word(2'd3, 2'($urandom()), $urandom(), 3'($urandom()));
    endfunction

    task automatic check_field(string name, longint expv, longint actv);
        if (expv != actv)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch %s: expected %0d got %0d", name, expv, actv);
        end
    endtask

    // response checker and receiver stalls
    initial
    begin
        ffea_pkg::rsp_t e;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
            begin
                result_count++;
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word: status %0d", rsp.status);
                end
                else
                begin
                    e = pending_results.pop_front();
                    check_field("status", e.status, rsp.status);
                    check_field("base_cylinder", e.base_cylinder, rsp.base_cylinder);
                    check_field("base_sector", e.base_sector, rsp.base_sector);
                    check_field("extent_length", e.extent_length, rsp.extent_length);
                    check_field("extent_kind", e.extent_kind, rsp.extent_kind);
                    check_field("entries_in_use", e.entries_in_use, rsp.entries_in_use);
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= quiet_run || ($urandom_range(99) >= 27);
        end
    end

    task automatic test_create_checks();
        send_word(make_word(ffea_pkg::CMD_CREATE, 2'd0, 32'd1, 3'd0));
        send_word(make_word(ffea_pkg::CMD_CREATE, 2'd1, 32'd254, 3'd7));
        send_word(make_word(ffea_pkg::CMD_CREATE, 2'd2, 32'd1, 3'd0));
        send_word(make_word(ffea_pkg::CMD_CREATE, ffea_pkg::KIND_INVALID, 32'd5, 3'd0));
        send_word(make_word(ffea_pkg::CMD_CREATE, 2'd0, 32'd0, 3'd0));
        send_word(make_word(ffea_pkg::CMD_CREATE, ffea_pkg::KIND_INVALID, 32'd0, 3'd0));
        send_word(make_word(ffea_pkg::CMD_READ, 2'd0, 32'd0, 3'd0));
        send_word(make_word(ffea_pkg::CMD_READ, 2'd3, 32'hFFFF_FFFF, 3'd1));
        send_word(make_word(ffea_pkg::CMD_READ, 2'd0, 32'd0, 3'd7));
        send_word(make_word(ffea_pkg::CMD_DELETE, 2'd0, 32'd0, 3'd5));
        send_word(make_word(ffea_pkg::CMD_DELETE, 2'd0, 32'd0, 3'd0));
        send_word(make_word(ffea_pkg::CMD_READ, 2'd0, 32'd0, 3'd0));
        send_word(make_word(2'd3, 2'd3, 32'hFFFF_FFFF, 3'd7));
        send_word(make_word(ffea_pkg::CMD_CREATE, 2'd2, 32'hFFFF_FFFF, 3'd0));
        send_word(make_word(ffea_pkg::CMD_DELETE, 2'd0, 32'd0, 3'd0));
    endtask

    task automatic test_fill_and_full();
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_word(make_word(ffea_pkg::CMD_CREATE, 2'(i % 3), 32'd10 + 32'(i), 3'd0));
        send_word(make_word(ffea_pkg::CMD_CREATE, ffea_pkg::KIND_INVALID, 32'd0, 3'd0));
        send_word(make_word(ffea_pkg::CMD_READ, 2'd0, 32'd0, 3'd7));
        send_word(make_word(ffea_pkg::CMD_DELETE, 2'd0, 32'd0, 3'd3));
        send_word(make_word(ffea_pkg::CMD_CREATE, 2'd1, 32'd1, 3'd0));
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_cycles = 600;
        for (int i = 0; i < 20; i++)
            send_word(random_word());
    endtask

    task automatic test_random_geometry();
        logic [15:0] spc_list [7] = '{16'd16, 16'd1, 16'd65535, 16'd0, 16'd300, 16'd65535,
                                      16'd7};
        logic [15:0] cyl_list [7] = '{16'd16, 16'd65535, 16'd1, 16'd40, 16'd200, 16'd65535,
                                      16'd3};
        for (int p = 0; p < 7; p++)
        begin
            set_geometry(spc_list[p], cyl_list[p]);
            quiet_run = (p == 2);
            for (int i = 0; i < 125; i++)
                send_word(random_word());
        end
        quiet_run = 0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        cfg_we <= 1'b0;
        cfg_index <= ffea_pkg::CFG_SPC;
        cfg_data <= '0;
        geo_spc = 16'd16;
        geo_cyl = 16'd16;
        vol_count = 0;
        mismatch_count = 0;
        result_count = 0;
        creates_placed = 0;
        hold_cycles = 0;
        quiet_run = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_create_checks();
        test_fill_and_full();
        test_backpressure();
        test_random_geometry();

        wait_drained();
        repeat (200) @(posedge clk);
        $display("checked %0d words over 7 disk geometries, %0d extents placed",
                 result_count, creates_placed);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
